// ===== hdl/obstacle_triggered_sampling_sequencer_core_macros.svh =====
// assertion macros for the sampling stop sequencer
// included by the top level; no other dependencies
`ifndef OBSTACLE_TRIGGERED_SAMPLING_SEQUENCER_CORE_MACROS_SVH
`define OBSTACLE_TRIGGERED_SAMPLING_SEQUENCER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define OTSS_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("otss invariant violated");

`define OTSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("otss implication violated");

`define OTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("otss next-cycle check violated");

`else

`define OTSS_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define OTSS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define OTSS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hdl/otss_pkg.sv =====
// types, codes and reset values for the sampling stop sequencer
// no dependencies; imported by otss_step and the top level
package otss_pkg;

    typedef enum logic [1:0] {
        PH_DRIVING   = 2'd0,
        PH_ACQUIRING = 2'd1,
        PH_READINGS  = 2'd2,
        PH_RESULT    = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ACT_RANGE   = 2'd0,
        ACT_TICK    = 2'd1,
        ACT_CLIMATE = 2'd2,
        ACT_LIGHT   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        REP_NONE    = 2'd0,
        REP_SAMPLE  = 2'd1,
        REP_FAILURE = 2'd2
    } t_report;

    typedef enum logic [2:0] {
        CFG_NEAR_LIMIT      = 3'd0,
        CFG_CLEAR_LIMIT     = 3'd1,
        CFG_CLEAR_HOLD      = 3'd2,
        CFG_ACQUIRE_TIMEOUT = 3'd3,
        CFG_READINGS_HOLD   = 3'd4,
        CFG_RESULT_HOLD     = 3'd5,
        CFG_LIGHT_SETTLE    = 3'd6,
        CFG_NO_ECHO         = 3'd7
    } t_cfg_index;

    typedef struct packed {
        logic [15:0] near_limit_cm;
        logic [15:0] clear_limit_cm;
        logic [31:0] clear_hold_ms;
        logic [31:0] acquire_timeout_ms;
        logic [31:0] readings_hold_ms;
        logic [31:0] result_hold_ms;
        logic [31:0] light_settle_ms;
        logic [15:0] no_echo_code;
    } t_cfg;

    typedef struct packed {
        t_action            action;
        logic [31:0]        time_ms;
        logic [15:0]        range_cm;
        logic               sensor_ok;
        logic signed [15:0] temperature;
        logic [7:0]         humidity_pct;
        logic [15:0]        light_level;
    } t_item;

    typedef struct packed {
        t_phase             phase;
        logic               armed;
        logic               near;
        logic               clearing;
        logic               climate_done;
        logic               lux_done;
        logic               ok;
        logic               paused;
        logic [31:0]        phase_start_ms;
        logic [31:0]        clear_start_ms;
        logic signed [15:0] held_temperature;
        logic [7:0]         held_humidity;
        logic [15:0]        held_light;
    } t_state;

    typedef struct packed {
        t_phase             phase;
        logic               stop_triggered;
        logic               object_near;
        logic               want_climate;
        logic               want_light;
        logic               all_ok;
        logic               drive_paused;
        t_report            report_kind;
        logic signed [15:0] report_temperature;
        logic [7:0]         report_humidity;
        logic [15:0]        report_light;
    } t_result;

    localparam t_cfg CFG_RESET = '{
        near_limit_cm:      16'd20,
        clear_limit_cm:     16'd40,
        clear_hold_ms:      32'd1000,
        acquire_timeout_ms: 32'd3000,
        readings_hold_ms:   32'd3000,
        result_hold_ms:     32'd2000,
        light_settle_ms:    32'd200,
        no_echo_code:       16'hFFFF
    };

    localparam t_state STATE_RESET = '{
        phase:            PH_DRIVING,
        armed:            1'b1,
        near:             1'b0,
        clearing:         1'b0,
        climate_done:     1'b0,
        lux_done:         1'b0,
        ok:               1'b0,
        paused:           1'b0,
        phase_start_ms:   32'd0,
        clear_start_ms:   32'd0,
        held_temperature: 16'sd0,
        held_humidity:    8'd0,
        held_light:       16'd0
    };

endpackage

// ===== hdl/obstacle_triggered_sampling_sequencer_core.sv =====
// top level of the rover sampling stop sequencer: request and result registers,
// configuration registers and sequencer state; depends on otss_pkg, otss_step
// and the assertion macro header
//
// Each accepted request (range reading, tick, climate or light completion) yields
// exactly one result: the request waits in the input register until the result
// register is free, then the state update by otss_step loads the result register. A
// request can be taken every cycle while the result side is not stalled; the
// sequencer state is updated combinationally by otss_step, so back-to-back requests
// see each other's effects in order. When the result register is stalled, one
// further request is held in the input register before ready drops. Configuration
// writes are always taken and should only be issued while no request is in flight.
`include "obstacle_triggered_sampling_sequencer_core_macros.svh"

module obstacle_triggered_sampling_sequencer_core import otss_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_action,
    input  logic [31:0]        i_time_ms,
    input  logic [15:0]        i_range_cm,
    input  logic               i_sensor_ok,
    input  logic signed [15:0] i_temperature,
    input  logic [7:0]         i_humidity_pct,
    input  logic [15:0]        i_light_level,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_phase,
    output logic               o_stop_triggered,
    output logic               o_object_near,
    output logic               o_want_climate,
    output logic               o_want_light,
    output logic               o_all_ok,
    output logic               o_drive_paused,
    output logic [1:0]         o_report_kind,
    output logic signed [15:0] o_report_temperature,
    output logic [7:0]         o_report_humidity,
    output logic [15:0]        o_report_light,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    logic    r_in_valid;
    logic    n_in_valid;
    t_item   r_in;
    t_item   n_in;
    logic    r_out_valid;
    logic    n_out_valid;
    t_result r_out;
    t_result n_out;
    t_state  r_state;
    t_state  n_state;
    t_cfg    r_cfg;
    t_cfg    n_cfg;

    t_state  w_step_state;
    t_result w_step_result;
    logic    w_in_accept;
    logic    w_advance;

    assign o_cfg_ready = 1'b1;
    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign w_in_accept = i_in_valid && o_in_ready;

    otss_step u_step (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in),
        .o_state  (w_step_state),
        .o_result (w_step_result)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        n_in       = r_in;
        if (w_in_accept) begin
            n_in_valid       = 1'b1;
            n_in.action      = t_action'(i_action);
            n_in.time_ms     = i_time_ms;
            n_in.range_cm    = i_range_cm;
            n_in.sensor_ok   = i_sensor_ok;
            n_in.temperature = i_temperature;
            n_in.humidity_pct = i_humidity_pct;
            n_in.light_level = i_light_level;
        end else if (w_advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_comb begin
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_state     = r_state;
        if (w_advance) begin
            n_out_valid = 1'b1;
            n_out       = w_step_result;
            n_state     = w_step_state;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_NEAR_LIMIT:      n_cfg.near_limit_cm      = i_cfg_data[15:0];
                CFG_CLEAR_LIMIT:     n_cfg.clear_limit_cm     = i_cfg_data[15:0];
                CFG_CLEAR_HOLD:      n_cfg.clear_hold_ms      = i_cfg_data;
                CFG_ACQUIRE_TIMEOUT: n_cfg.acquire_timeout_ms = i_cfg_data;
                CFG_READINGS_HOLD:   n_cfg.readings_hold_ms   = i_cfg_data;
                CFG_RESULT_HOLD:     n_cfg.result_hold_ms     = i_cfg_data;
                CFG_LIGHT_SETTLE:    n_cfg.light_settle_ms    = i_cfg_data;
                CFG_NO_ECHO:         n_cfg.no_echo_code       = i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
            r_cfg       <= CFG_RESET;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_state     <= n_state;
            r_cfg       <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in  <= n_in;
        r_out <= n_out;
    end

    assign o_out_valid          = r_out_valid;
    assign o_phase              = r_out.phase;
    assign o_stop_triggered     = r_out.stop_triggered;
    assign o_object_near        = r_out.object_near;
    assign o_want_climate       = r_out.want_climate;
    assign o_want_light         = r_out.want_light;
    assign o_all_ok             = r_out.all_ok;
    assign o_drive_paused       = r_out.drive_paused;
    assign o_report_kind        = r_out.report_kind;
    assign o_report_temperature = r_out.report_temperature;
    assign o_report_humidity    = r_out.report_humidity;
    assign o_report_light       = r_out.report_light;

    // drive is held exactly while a stop is in progress
    `OTSS_ASSERT_ALWAYS(a_paused_matches_phase, i_clk, i_rst_n, r_state.paused == (r_state.phase != PH_DRIVING))
    // an armed sequencer never has a clearance timer running
    `OTSS_ASSERT_IMPLY(a_armed_not_clearing, i_clk, i_rst_n, r_state.armed, !r_state.clearing)
    // a report only leaves together with the entry into the readings phase
    `OTSS_ASSERT_IMPLY(a_report_in_readings, i_clk, i_rst_n, r_out_valid && (r_out.report_kind != REP_NONE), r_out.phase == PH_READINGS)
    // a pending request is never dropped while the result register is blocked
    `OTSS_ASSERT_NEXT(a_pending_kept, i_clk, i_rst_n, r_in_valid && !w_advance, r_in_valid)

endmodule

// ===== hdl/otss_step.sv =====
// next-state and result logic for one request of the sampling stop sequencer
// depends on otss_pkg
module otss_step import otss_pkg::*; (
    input  t_state  i_state,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_state  o_state,
    output t_result o_result
);

    logic [31:0] w_el_phase;
    logic [31:0] w_el_clear;
    logic [31:0] w_el_next;
    logic        w_near;
    logic        w_clear;
    logic        w_trig;
    t_report     w_kind;

    assign w_el_phase = i_item.time_ms - i_state.phase_start_ms;
    assign w_el_clear = i_item.time_ms - i_state.clear_start_ms;
    assign w_near  = (i_item.range_cm != i_cfg.no_echo_code) &&
                     (i_item.range_cm <= i_cfg.near_limit_cm);
    assign w_clear = (i_item.range_cm == i_cfg.no_echo_code) ||
                     (i_item.range_cm > i_cfg.clear_limit_cm);

    always_comb begin
        logic armed;
        logic both;
        logic ok_end;
        o_state = i_state;
        w_trig  = 1'b0;
        w_kind  = REP_NONE;
        armed   = i_state.armed;
        both    = i_state.climate_done && i_state.lux_done;
        ok_end  = both && i_state.ok;
        case (i_item.action)
            ACT_RANGE: begin
                o_state.near = w_near;
                if (i_state.phase == PH_DRIVING) begin
                    if (!i_state.armed) begin
                        if (!w_clear) begin
                            o_state.clearing = 1'b0;
                        end else if (!i_state.clearing) begin
                            o_state.clear_start_ms = i_item.time_ms;
                            o_state.clearing       = 1'b1;
                        end else if (w_el_clear >= i_cfg.clear_hold_ms) begin
                            armed            = 1'b1;
                            o_state.clearing = 1'b0;
                        end
                    end
                    o_state.armed = armed;
                    if (armed && w_near) begin
                        w_trig               = 1'b1;
                        o_state.armed        = 1'b0;
                        o_state.clearing     = 1'b0;
                        o_state.climate_done = 1'b0;
                        o_state.lux_done     = 1'b0;
                        o_state.ok           = 1'b1;
                        o_state.phase        = PH_ACQUIRING;
                        o_state.phase_start_ms = i_item.time_ms;
                        o_state.paused       = 1'b1;
                    end
                end
            end
            ACT_TICK: begin
                case (i_state.phase)
                    PH_ACQUIRING: begin
                        if (both || (w_el_phase >= i_cfg.acquire_timeout_ms)) begin
                            o_state.ok             = ok_end;
                            w_kind                 = ok_end ? REP_SAMPLE : REP_FAILURE;
                            o_state.phase          = PH_READINGS;
                            o_state.phase_start_ms = i_item.time_ms;
                        end
                    end
                    PH_READINGS: begin
                        if (w_el_phase >= i_cfg.readings_hold_ms) begin
                            o_state.phase          = PH_RESULT;
                            o_state.phase_start_ms = i_item.time_ms;
                        end
                    end
                    PH_RESULT: begin
                        if (w_el_phase >= i_cfg.result_hold_ms) begin
                            o_state.phase    = PH_DRIVING;
                            o_state.clearing = 1'b0;
                            o_state.paused   = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            ACT_CLIMATE: begin
                if ((i_state.phase == PH_ACQUIRING) && !i_state.climate_done) begin
                    o_state.climate_done     = 1'b1;
                    o_state.held_temperature = i_item.temperature;
                    o_state.held_humidity    = i_item.humidity_pct;
                    o_state.ok               = i_state.ok && i_item.sensor_ok;
                end
            end
            ACT_LIGHT: begin
                if ((i_state.phase == PH_ACQUIRING) && !i_state.lux_done) begin
                    o_state.lux_done   = 1'b1;
                    o_state.held_light = i_item.light_level;
                    o_state.ok         = i_state.ok && i_item.sensor_ok;
                end
            end
            default: begin
            end
        endcase
    end

    // light request is judged against the phase start after this request
    assign w_el_next = i_item.time_ms - o_state.phase_start_ms;

    always_comb begin
        o_result.phase          = o_state.phase;
        o_result.stop_triggered = w_trig;
        o_result.object_near    = o_state.near;
        o_result.want_climate   = (o_state.phase == PH_ACQUIRING) && !o_state.climate_done;
        o_result.want_light     = (o_state.phase == PH_ACQUIRING) && !o_state.lux_done &&
                                  (w_el_next >= i_cfg.light_settle_ms);
        o_result.all_ok         = o_state.ok;
        o_result.drive_paused   = o_state.paused;
        o_result.report_kind    = w_kind;
        if (w_kind == REP_SAMPLE) begin
            o_result.report_temperature = o_state.held_temperature;
            o_result.report_humidity    = o_state.held_humidity;
            o_result.report_light       = o_state.held_light;
        end else begin
            o_result.report_temperature = 16'sd0;
            o_result.report_humidity    = 8'd0;
            o_result.report_light       = 16'd0;
        end
    end

endmodule

// ===== test/tb_obstacle_triggered_sampling_sequencer_core.sv =====
// testbench for obstacle_triggered_sampling_sequencer_core: a directed table, then random
// request traffic under several register settings, every result checked against a typed status or a predictor
// depends on otss_pkg and the core
module tb_obstacle_triggered_sampling_sequencer_core import otss_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] DIR_T0 = 32'hFFFF_FF00;

    typedef struct {
        t_item   item;
        logic    typed_in;
        t_result typed_status;
    } t_stim_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [1:0]         i_action;
    logic [31:0]        i_time_ms;
    logic [15:0]        i_range_cm;
    logic               i_sensor_ok;
    logic signed [15:0] i_temperature;
    logic [7:0]         i_humidity_pct;
    logic [15:0]        i_light_level;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_phase;
    logic               o_stop_triggered;
    logic               o_object_near;
    logic               o_want_climate;
    logic               o_want_light;
    logic               o_all_ok;
    logic               o_drive_paused;
    logic [1:0]         o_report_kind;
    logic signed [15:0] o_report_temperature;
    logic [7:0]         o_report_humidity;
    logic [15:0]        o_report_light;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [2:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;

    t_cfg        cfg_now = CFG_RESET;
    t_state      seq = STATE_RESET;
    t_result     expected_status[$];
    t_result     seen_status;
    t_stim_row   stim_rows[$];
    logic [31:0] ms_now;
    int unsigned ms_step_max;
    int          burst_left = 0;
    int          mismatch_count = 0;
    int          results_seen = 0;
    int          stall_left = 0;
    int          stall_mode = 0;
    logic [7:0]  stall_bits;

    obstacle_triggered_sampling_sequencer_core u_top (.*);

    always #6 i_clk = ~i_clk;

    function automatic logic [31:0] ms_since(logic [31:0] now, logic [31:0] start);
        return now - start;
    endfunction

    function automatic t_result step_sequencer(t_item it);
        t_result r;
        logic    clear_view;
        logic    both_in;
        r = '0;
        case (it.action)
            ACT_RANGE: begin
                seq.near = (it.range_cm != cfg_now.no_echo_code) &&
                           (it.range_cm <= cfg_now.near_limit_cm);
                if (seq.phase == PH_DRIVING) begin
                    if (!seq.armed) begin
                        clear_view = (it.range_cm == cfg_now.no_echo_code) ||
                                     (it.range_cm > cfg_now.clear_limit_cm);
                        if (!clear_view) begin
                            seq.clearing = 1'b0;
                        end else if (!seq.clearing) begin
                            seq.clear_start_ms = it.time_ms;
                            seq.clearing = 1'b1;
                        end else if (ms_since(it.time_ms, seq.clear_start_ms) >=
                                     cfg_now.clear_hold_ms) begin
                            seq.armed = 1'b1;
                            seq.clearing = 1'b0;
                        end
                    end
                    if (seq.armed && seq.near) begin
                        seq.armed = 1'b0;
                        seq.clearing = 1'b0;
                        seq.climate_done = 1'b0;
                        seq.lux_done = 1'b0;
                        seq.ok = 1'b1;
                        seq.phase = PH_ACQUIRING;
                        seq.phase_start_ms = it.time_ms;
                        seq.paused = 1'b1;
                        r.stop_triggered = 1'b1;
                    end
                end
            end
            ACT_TICK: begin
                case (seq.phase)
                    PH_ACQUIRING: begin
                        both_in = seq.climate_done && seq.lux_done;
                        if (both_in || ms_since(it.time_ms, seq.phase_start_ms) >=
                                       cfg_now.acquire_timeout_ms) begin
                            if (!both_in) seq.ok = 1'b0;
                            if (seq.ok) r.report_kind = REP_SAMPLE;
                            else r.report_kind = REP_FAILURE;
                            seq.phase = PH_READINGS;
                            seq.phase_start_ms = it.time_ms;
                        end
                    end
                    PH_READINGS: begin
                        if (ms_since(it.time_ms, seq.phase_start_ms) >=
                            cfg_now.readings_hold_ms) begin
                            seq.phase = PH_RESULT;
                            seq.phase_start_ms = it.time_ms;
                        end
                    end
                    PH_RESULT: begin
                        if (ms_since(it.time_ms, seq.phase_start_ms) >=
                            cfg_now.result_hold_ms) begin
                            seq.phase = PH_DRIVING;
                            seq.clearing = 1'b0;
                            seq.paused = 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            ACT_CLIMATE: begin
                if (seq.phase == PH_ACQUIRING && !seq.climate_done) begin
                    seq.climate_done = 1'b1;
                    seq.held_temperature = it.temperature;
                    seq.held_humidity = it.humidity_pct;
                    seq.ok = seq.ok && it.sensor_ok;
                end
            end
            default: begin
                if (seq.phase == PH_ACQUIRING && !seq.lux_done) begin
                    seq.lux_done = 1'b1;
                    seq.held_light = it.light_level;
                    seq.ok = seq.ok && it.sensor_ok;
                end
            end
        endcase
        r.phase = seq.phase;
        r.object_near = seq.near;
        r.want_climate = (seq.phase == PH_ACQUIRING) && !seq.climate_done;
        r.want_light = (seq.phase == PH_ACQUIRING) && !seq.lux_done &&
                       (ms_since(it.time_ms, seq.phase_start_ms) >= cfg_now.light_settle_ms);
        r.all_ok = seq.ok;
        r.drive_paused = seq.paused;
        if (r.report_kind == REP_SAMPLE) begin
            r.report_temperature = seq.held_temperature;
            r.report_humidity = seq.held_humidity;
            r.report_light = seq.held_light;
        end
        return r;
    endfunction

    function automatic t_item mk_request(t_action a, logic [31:0] dt, logic [15:0] range_cm,
                                         logic ok, logic [15:0] temp, logic [7:0] hum,
                                         logic [15:0] lux);
        t_item it;
        it.action = a;
        it.time_ms = DIR_T0 + dt;
        it.range_cm = range_cm;
        it.sensor_ok = ok;
        it.temperature = temp;
        it.humidity_pct = hum;
        it.light_level = lux;
        return it;
    endfunction

    function automatic t_result status(t_phase ph, logic trig, logic near_obj, logic wc,
                                       logic wl, logic ok, logic paused);
        t_result r;
        r = '0;
        r.phase = ph;
        r.stop_triggered = trig;
        r.object_near = near_obj;
        r.want_climate = wc;
        r.want_light = wl;
        r.all_ok = ok;
        r.drive_paused = paused;
        return r;
    endfunction

    function automatic t_item pick_request();
        t_item       it;
        int unsigned roll;
        it.range_cm = 16'($urandom);
        it.sensor_ok = ($urandom_range(0, 9) != 0);
        it.temperature = 16'($urandom);
        it.humidity_pct = 8'($urandom);
        it.light_level = 16'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 3) ms_now = $urandom;
        else if (roll < 50) ms_now = ms_now + $urandom_range(0, 3);
        else ms_now = ms_now + $urandom_range(0, ms_step_max);
        it.time_ms = ms_now;
        roll = $urandom_range(0, 99);
        if (roll < 12) begin
            it.action = t_action'($urandom_range(0, 3));
            it.sensor_ok = 1'($urandom_range(0, 1));
        end else if (seq.phase == PH_DRIVING) begin
            if (roll < 85) it.action = ACT_RANGE;
            else it.action = ACT_TICK;
        end else if (seq.phase == PH_ACQUIRING) begin
            if (roll < 45) it.action = ACT_CLIMATE;
            else if (roll < 75) it.action = ACT_LIGHT;
            else it.action = ACT_TICK;
        end else begin
            if (roll < 85) it.action = ACT_TICK;
            else it.action = ACT_RANGE;
        end
        if (seq.phase == PH_DRIVING && !seq.armed && $urandom_range(0, 3) != 0) begin
            if ($urandom_range(0, 1) == 0) it.range_cm = cfg_now.no_echo_code;
            else it.range_cm = cfg_now.clear_limit_cm + 16'($urandom_range(1, 200));
        end else begin
            case ($urandom_range(0, 7))
                0: it.range_cm = cfg_now.near_limit_cm;
                1: it.range_cm = cfg_now.near_limit_cm + 16'd1;
                2: it.range_cm = cfg_now.clear_limit_cm;
                3: it.range_cm = cfg_now.clear_limit_cm + 16'd1;
                4: it.range_cm = cfg_now.no_echo_code;
                5: it.range_cm = 16'($urandom_range(0, cfg_now.near_limit_cm));
                6: ;
                default: it.range_cm = cfg_now.clear_limit_cm + 16'($urandom_range(1, 200));
            endcase
        end
        return it;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= 100)
            $display("tb: result %0d %s got %0h want %0h", results_seen, what, got, want);
    endtask

    task automatic check_status(t_result got, t_result want);
        if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
        if (got.stop_triggered !== want.stop_triggered)
            report_mismatch("stop_triggered", got.stop_triggered, want.stop_triggered);
        if (got.object_near !== want.object_near)
            report_mismatch("object_near", got.object_near, want.object_near);
        if (got.want_climate !== want.want_climate)
            report_mismatch("want_climate", got.want_climate, want.want_climate);
        if (got.want_light !== want.want_light)
            report_mismatch("want_light", got.want_light, want.want_light);
        if (got.all_ok !== want.all_ok) report_mismatch("all_ok", got.all_ok, want.all_ok);
        if (got.drive_paused !== want.drive_paused)
            report_mismatch("drive_paused", got.drive_paused, want.drive_paused);
        if (got.report_kind !== want.report_kind)
            report_mismatch("report_kind", got.report_kind, want.report_kind);
        if (got.report_temperature !== want.report_temperature)
            report_mismatch("report_temperature", got.report_temperature,
                            want.report_temperature);
        if (got.report_humidity !== want.report_humidity)
            report_mismatch("report_humidity", got.report_humidity, want.report_humidity);
        if (got.report_light !== want.report_light)
            report_mismatch("report_light", got.report_light, want.report_light);
    endtask

    task automatic send_request(t_item it, logic typed_in, t_result typed_status);
        int unsigned gap;
        t_result     predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        i_action <= it.action;
        i_time_ms <= it.time_ms;
        i_range_cm <= it.range_cm;
        i_sensor_ok <= it.sensor_ok;
        i_temperature <= it.temperature;
        i_humidity_pct <= it.humidity_pct;
        i_light_level <= it.light_level;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = step_sequencer(it);
        if (typed_in) expected_status.push_back(typed_status);
        else expected_status.push_back(predicted);
        @(negedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, logic [31:0] data);
        i_cfg_index <= idx;
        i_cfg_data <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_NEAR_LIMIT:      cfg_now.near_limit_cm = data[15:0];
            CFG_CLEAR_LIMIT:     cfg_now.clear_limit_cm = data[15:0];
            CFG_CLEAR_HOLD:      cfg_now.clear_hold_ms = data;
            CFG_ACQUIRE_TIMEOUT: cfg_now.acquire_timeout_ms = data;
            CFG_READINGS_HOLD:   cfg_now.readings_hold_ms = data;
            CFG_RESULT_HOLD:     cfg_now.result_hold_ms = data;
            CFG_LIGHT_SETTLE:    cfg_now.light_settle_ms = data;
            default:             cfg_now.no_echo_code = data[15:0];
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_settings(t_cfg s);
        write_register(CFG_NEAR_LIMIT, {16'($urandom), s.near_limit_cm});
        write_register(CFG_CLEAR_LIMIT, {16'($urandom), s.clear_limit_cm});
        write_register(CFG_CLEAR_HOLD, s.clear_hold_ms);
        write_register(CFG_ACQUIRE_TIMEOUT, s.acquire_timeout_ms);
        write_register(CFG_READINGS_HOLD, s.readings_hold_ms);
        write_register(CFG_RESULT_HOLD, s.result_hold_ms);
        write_register(CFG_LIGHT_SETTLE, s.light_settle_ms);
        write_register(CFG_NO_ECHO, {16'($urandom), s.no_echo_code});
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain_requests();
        i_in_valid <= 1'b0;
        while (expected_status.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // result side ready follows one of four randomly chosen stall patterns, chosen anew when stall_left runs out
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_bits = 8'($urandom) | 8'h01;
            stall_left = $urandom_range(16, 96);
        end
        stall_left--;
        case (stall_mode)
            0: i_out_ready <= 1'b1;
            1: i_out_ready <= 1'($urandom_range(0, 1));
            2: begin
                i_out_ready <= stall_bits[0];
                stall_bits = {stall_bits[0], stall_bits[7:1]};
            end
            default: i_out_ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            seen_status.phase = t_phase'(o_phase);
            seen_status.stop_triggered = o_stop_triggered;
            seen_status.object_near = o_object_near;
            seen_status.want_climate = o_want_climate;
            seen_status.want_light = o_want_light;
            seen_status.all_ok = o_all_ok;
            seen_status.drive_paused = o_drive_paused;
            seen_status.report_kind = t_report'(o_report_kind);
            seen_status.report_temperature = o_report_temperature;
            seen_status.report_humidity = o_report_humidity;
            seen_status.report_light = o_report_light;
            results_seen++;
            if (expected_status.size() == 0) report_mismatch("unexpected result", '0, '0);
            else check_status(seen_status, expected_status.pop_front());
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_cfg    s;
        t_result idle;
        idle = status(PH_DRIVING, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_action = ACT_RANGE;
        i_time_ms = '0;
        i_range_cm = '0;
        i_sensor_ok = 1'b0;
        i_temperature = '0;
        i_humidity_pct = '0;
        i_light_level = '0;
        i_out_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_NEAR_LIMIT;
        i_cfg_data = '0;

        // first stop completes, second one times out with a failed climate reading
        stim_rows.push_back('{mk_request(ACT_TICK, 0, 0, 0, 0, 0, 0), 1'b1, idle});
        stim_rows.push_back('{mk_request(ACT_CLIMATE, 5, 0, 1, 100, 50, 0), 1'b1, idle});
        stim_rows.push_back('{mk_request(ACT_LIGHT, 6, 0, 1, 0, 0, 7), 1'b1, idle});
        stim_rows.push_back('{mk_request(ACT_RANGE, 10, 16'hFFFF, 0, 0, 0, 0), 1'b1, idle});
        stim_rows.push_back('{mk_request(ACT_RANGE, 20, 21, 0, 0, 0, 0), 1'b1, idle});
        stim_rows.push_back('{mk_request(ACT_RANGE, 30, 20, 0, 0, 0, 0), 1'b1,
                              status(PH_ACQUIRING, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1)});
        stim_rows.push_back('{mk_request(ACT_TICK, 229, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_TICK, 230, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_CLIMATE, 240, 0, 1, 16'h8000, 255, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_CLIMATE, 250, 0, 0, 5, 5, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_LIGHT, 260, 0, 1, 0, 0, 16'hFFFF), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_LIGHT, 265, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_RANGE, 270, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_TICK, 280, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_TICK, 3279, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_TICK, 3280, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_TICK, 5280, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_RANGE, 5290, 10, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_RANGE, 5300, 41, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_RANGE, 6300, 16'hFFFF, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_RANGE, 6310, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_CLIMATE, 6320, 0, 0, 16'h7FFF, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_TICK, 9310, 0, 0, 0, 0, 0), 1'b0, '0});
        stim_rows.push_back('{mk_request(ACT_LIGHT, 9320, 0, 1, 0, 0, 9), 1'b0, '0});

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (stim_rows[k]) send_request(stim_rows[k].item, stim_rows[k].typed_in,
                                            stim_rows[k].typed_status);
        ms_now = DIR_T0 + 32'd9320;

        for (int ph = 0; ph < 6; ph++) begin
            drain_requests();
            case (ph)
                0: begin
                    s = '0;
                    ms_step_max = 4;
                end
                1: begin
                    s = '1;
                    ms_step_max = 2000;
                end
                3: begin
                    s = CFG_RESET;
                    ms_step_max = 800;
                end
                4: begin
                    // inverted hysteresis, settle longer than the timeout
                    s.near_limit_cm = 16'($urandom_range(100, 400));
                    s.clear_limit_cm = 16'($urandom_range(0, 99));
                    s.clear_hold_ms = $urandom_range(0, 300);
                    s.acquire_timeout_ms = $urandom_range(0, 100);
                    s.readings_hold_ms = $urandom_range(0, 300);
                    s.result_hold_ms = $urandom_range(0, 300);
                    s.light_settle_ms = $urandom_range(101, 300);
                    s.no_echo_code = s.near_limit_cm;
                    ms_step_max = 100;
                end
                default: begin
                    s.near_limit_cm = 16'($urandom_range(0, 300));
                    s.clear_limit_cm = s.near_limit_cm + 16'($urandom_range(0, 200));
                    s.clear_hold_ms = $urandom_range(0, 400);
                    s.acquire_timeout_ms = $urandom_range(0, 400);
                    s.readings_hold_ms = $urandom_range(0, 400);
                    s.result_hold_ms = $urandom_range(0, 400);
                    s.light_settle_ms = $urandom_range(0, 400);
                    s.no_echo_code = 16'($urandom_range(0, 500));
                    ms_step_max = 150;
                end
            endcase
            load_settings(s);
            repeat (221) send_request(pick_request(), 1'b0, '0);
        end

        drain_requests();
        if (mismatch_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
